@@ design/swmp_pkg.sv @@
// ============================================================================
// swmp_pkg: shared types and constants
// Constants, state codes and helpers for the sliding window statistics block.
// ============================================================================
package swmp_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int PCT_FULL     = 10000;
    localparam int CNT_W        = 7;
    localparam int PCT_W        = 14;
    localparam int SAMPLE_W     = 32;
    localparam int MEAN_W       = 40;

    // Reciprocal of PCT_FULL scaled by 2**RCP_SHIFT, rounded up. The product
    // stays exact for dividends below 2**34 / 816, far above p*n + 9999.
    localparam int              RCP_W     = 21;
    localparam int              RCP_SHIFT = 34;
    localparam logic [RCP_W-1:0] RCP_MUL  = 21'd1717987;

    localparam logic [0:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [0:0] REG_TARGET_PCT    = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OLD,
        ST_SCAN,
        ST_SHIFT,
        ST_INS_SCAN,
        ST_DIV,
        ST_RANK_MUL,
        ST_RANK,
        ST_RANK_RD,
        ST_OUT
    } state_t;

endpackage

@@ design/swmp_divider.sv @@
// ============================================================================
// swmp_divider: restoring divider
// Divides the scaled window sum by the sample count, one quotient bit a cycle.
// ============================================================================
module swmp_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int IW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [IW-1:0]    i_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    always_comb begin
        trial = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        diff  = trial - {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                q_reg    <= numer;
                r_reg    <= '0;
                d_reg    <= denom;
                i_reg    <= IW'(NUM_W);
            end else if (busy_reg) begin
                if (trial >= {1'b0, d_reg}) begin
                    r_reg <= diff;
                    q_reg <= {q_reg[NUM_W-2:0], 1'b1};
                end else begin
                    r_reg <= trial;
                    q_reg <= {q_reg[NUM_W-2:0], 1'b0};
                end
                i_reg <= i_reg - 1'b1;
                if (i_reg == IW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

@@ design/sliding_window_mean_percentile.sv @@
// ============================================================================
// sliding_window_mean_percentile: windowed mean and percentiles
// Keeps recent samples in an arrival ring and a sorted memory and reports
// count, mean and four nearest-rank percentiles per sample.
// ============================================================================
//  Channel  Ports             Direction  Transaction
//  s_       valid/ready       in         one sample
//  m_       valid/ready       out        count, mean, four percentiles
//  apb      psel..pready      in         window_length, target_percentile
//
//  From acceptance to a valid result, the sorted memory is walked one entry
//  a cycle for removal (with a full window) and insertion, the mean divider
//  then runs, and each of the four rank reads passes through ST_RANK_MUL,
//  ST_RANK and ST_RANK_RD.
//  Reset is synchronous; the memories need no clearing pass.
//  A stalled result holds in the output registers; no new sample is taken
//  until it is delivered.
module sliding_window_mean_percentile #(
    parameter int CAPACITY = swmp_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [swmp_pkg::SAMPLE_W-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [swmp_pkg::CNT_W-1:0]    m_count,
    output logic [swmp_pkg::MEAN_W-1:0]   m_mean,
    output logic [swmp_pkg::SAMPLE_W-1:0] m_selected,
    output logic [swmp_pkg::SAMPLE_W-1:0] m_median,
    output logic [swmp_pkg::SAMPLE_W-1:0] m_p95_value,
    output logic [swmp_pkg::SAMPLE_W-1:0] m_p99_value,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import swmp_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NW    = $clog2(CAPACITY + 1);
    localparam int SUM_W = SAMPLE_W + NW;
    localparam int NUM_W = SUM_W + 8;
    localparam int RW    = $clog2(CAPACITY * PCT_FULL + PCT_FULL);
    localparam int PW    = RW + RCP_W;

    logic [SAMPLE_W-1:0] ring_mem [CAPACITY];
    logic [SAMPLE_W-1:0] sort_mem [CAPACITY];

    state_t state_reg, state_next;
    logic [NW-1:0]       len_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic [AW-1:0]       oldest_reg;
    logic [NW-1:0]       held_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] smp_reg;
    logic [SAMPLE_W-1:0] old_reg;
    logic [NW-1:0]       idx_reg;
    logic [1:0]          rk_reg;
    logic [RW-1:0]       prod_reg;
    logic                out_valid_reg;
    logic [CNT_W-1:0]    o_count_reg;
    logic [MEAN_W-1:0]   o_mean_reg;
    logic [SAMPLE_W-1:0] o_pct_reg [4];

    logic [SAMPLE_W-1:0] ring_q, sort_q;
    logic                wr_cfg;
    logic                div_start, div_done;
    logic [NUM_W-1:0]    div_numer;
    logic [NUM_W-1:0]    div_q;
    logic [6:0]          wdata7;
    logic [PCT_W-1:0]    wdata14;
    logic [NW-1:0]       n_now;
    logic [AW-1:0]       wp;
    logic [PCT_W-1:0]    rk_pct;
    logic [RW-1:0]       rank_raw;
    logic [NW-1:0]       rank_idx;

    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;
    assign wdata7 = pwdata[6:0];
    assign wdata14 = pwdata[13:0];

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_WINDOW_LENGTH: prdata = 32'(len_reg);
            REG_TARGET_PCT:    prdata = 32'(pct_reg);
            default:           prdata = '0;
        endcase
    end

    // Ring write position for a sample that does not evict.
    always_comb begin
        logic [NW:0] s;
        s = {1'b0, NW'(oldest_reg)} + {1'b0, held_reg};
        if (s >= {1'b0, len_reg}) s = s - {1'b0, len_reg};
        wp = AW'(s);
    end

    always_comb begin
        case (rk_reg)
            2'd0:    rk_pct = pct_reg;
            2'd1:    rk_pct = PCT_W'(5000);
            2'd2:    rk_pct = PCT_W'(9500);
            default: rk_pct = PCT_W'(9900);
        endcase
    end

    // ceil(p*n/10000) from the registered p*n + 9999 by a reciprocal
    // multiplication; clamped to 1..n.
    always_comb begin
        logic [PW-1:0] scaled;
        scaled   = PW'(prod_reg) * PW'(RCP_MUL);
        rank_raw = RW'(scaled >> RCP_SHIFT);
        if (rank_raw < RW'(1)) rank_idx = '0;
        else if (rank_raw > RW'(held_reg)) rank_idx = held_reg - 1'b1;
        else rank_idx = NW'(rank_raw) - 1'b1;
    end

    // The divider starts on the edge that commits the insertion, so it takes
    // the sum and count that include the new sample.
    assign n_now     = held_reg + 1'b1;
    assign div_numer = {sum_reg + SUM_W'(smp_reg), 8'd0};

    swmp_divider #(.NUM_W(NUM_W), .DEN_W(NW)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .numer  (div_numer),
        .denom  (n_now),
        .done   (div_done),
        .quot   (div_q)
    );

    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign div_start = (state_reg == ST_INS_SCAN) && (state_next == ST_DIV);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid && s_ready) begin
                state_next = (held_reg >= len_reg) ? ST_RD_OLD : ST_INS_SCAN;
            end
            ST_RD_OLD:    state_next = ST_SCAN;
            ST_SCAN:      if (sort_q == old_reg) state_next = ST_SHIFT;
            ST_SHIFT:     if (idx_reg + 1'b1 >= held_reg) state_next = ST_INS_SCAN;
            ST_INS_SCAN:  if (idx_reg == '0 || sort_q <= smp_reg) state_next = ST_DIV;
            ST_DIV:       if (div_done) state_next = ST_RANK_MUL;
            ST_RANK_MUL:  state_next = ST_RANK;
            ST_RANK:      state_next = ST_RANK_RD;
            ST_RANK_RD:   state_next = (rk_reg == 2'd3) ? ST_OUT : ST_RANK_MUL;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= NW'(CAPACITY < 64 ? CAPACITY : 64);
            pct_reg       <= PCT_W'(5000);
            oldest_reg    <= '0;
            held_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            rk_reg        <= '0;
            idx_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            if (wr_cfg && paddr[1:0] == 2'b00) begin
                if (paddr[2] == REG_WINDOW_LENGTH) begin
                    if (wdata7 == '0) len_reg <= NW'(1);
                    else if (32'(wdata7) > CAPACITY) len_reg <= NW'(CAPACITY);
                    else len_reg <= NW'(wdata7);
                    oldest_reg <= '0;
                    held_reg   <= '0;
                    sum_reg    <= '0;
                end else begin
                    pct_reg <= (wdata14 > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : wdata14;
                end
            end
            unique case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    smp_reg <= s_sample;
                    if (held_reg >= len_reg) begin
                        idx_reg <= '0;
                    end else begin
                        idx_reg <= held_reg;
                    end
                end
                ST_RD_OLD: begin
                    old_reg <= ring_q;
                    idx_reg <= '0;
                end
                ST_SCAN: begin
                    if (sort_q != old_reg) idx_reg <= idx_reg + 1'b1;
                end
                ST_SHIFT: begin
                    if (idx_reg + 1'b1 >= held_reg) begin
                        held_reg   <= held_reg - 1'b1;
                        sum_reg    <= sum_reg - SUM_W'(old_reg);
                        oldest_reg <= (NW'(oldest_reg) + 1'b1 >= len_reg) ? '0
                                      : oldest_reg + 1'b1;
                        idx_reg    <= held_reg - 1'b1;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_INS_SCAN: begin
                    if (idx_reg == '0 || sort_q <= smp_reg) begin
                        held_reg <= held_reg + 1'b1;
                        sum_reg  <= sum_reg + SUM_W'(smp_reg);
                    end else begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                ST_DIV: if (div_done) begin
                    o_mean_reg  <= MEAN_W'(div_q);
                    o_count_reg <= CNT_W'(held_reg);
                    rk_reg      <= '0;
                end
                ST_RANK_MUL: begin
                    prod_reg <= RW'(rk_pct) * RW'(held_reg) + RW'(PCT_FULL - 1);
                end
                ST_RANK: ;
                ST_RANK_RD: begin
                    o_pct_reg[rk_reg] <= sort_q;
                    rk_reg <= rk_reg + 1'b1;
                end
                ST_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Sorted memory: one read and one write port, read data registered.
    // Reads are set up so that sort_q holds the entry named last cycle.
    logic [AW-1:0]       s_raddr;
    logic                s_we;
    logic [AW-1:0]       s_waddr;
    logic [SAMPLE_W-1:0] s_wdata;
    logic                ins_hit;

    assign ins_hit = (idx_reg == '0) || (sort_q <= smp_reg);

    always_comb begin
        s_raddr = AW'(idx_reg);
        s_we    = 1'b0;
        s_waddr = AW'(idx_reg);
        s_wdata = sort_q;
        unique case (state_reg)
            ST_IDLE:     s_raddr = (held_reg >= len_reg) ? '0 : AW'(held_reg - 1'b1);
            ST_RD_OLD:   s_raddr = '0;
            ST_SCAN:     s_raddr = (sort_q == old_reg) ? AW'(idx_reg + 1'b1)
                                   : AW'(idx_reg + 1'b1);
            ST_SHIFT: begin
                // sort_q holds entry idx+1; move it down.
                s_we    = (idx_reg + 1'b1 < held_reg);
                s_waddr = AW'(idx_reg);
                s_wdata = sort_q;
                s_raddr = (idx_reg + 1'b1 >= held_reg) ? AW'(held_reg - 2'd2)
                          : AW'(idx_reg + 2'd2);
            end
            ST_INS_SCAN: begin
                // sort_q holds entry idx-1.
                s_we    = 1'b1;
                s_waddr = AW'(idx_reg);
                s_wdata = (ins_hit) ? smp_reg : sort_q;
                s_raddr = AW'(idx_reg - 2'd2);
            end
            ST_RANK:     s_raddr = AW'(rank_idx);
            default:     s_raddr = AW'(rank_idx);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_we) sort_mem[s_waddr] <= s_wdata;
        sort_q <= sort_mem[s_raddr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid && s_ready)
            ring_q <= ring_mem[oldest_reg];
        if (state_reg == ST_IDLE && s_valid && s_ready) begin
            if (held_reg >= len_reg) ring_mem[oldest_reg] <= s_sample;
            else ring_mem[wp] <= s_sample;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_count     = o_count_reg;
    assign m_mean      = o_mean_reg;
    assign m_selected  = o_pct_reg[0];
    assign m_median    = o_pct_reg[1];
    assign m_p95_value = o_pct_reg[2];
    assign m_p99_value = o_pct_reg[3];
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Sliding window statistics testbench
// Streams samples through the block under random idling on both channels,
// reprograms the window length and target percentile between phases, and
// checks count, mean and all four percentiles against a behavioral predictor.
// ============================================================================
module testbench;
    import swmp_pkg::*;

    localparam int DEPTH     = 64;
    localparam int LIMIT     = 2_000_000;
    localparam int SETTLE    = 20;
    localparam int TARGET_N  = 1300;

    typedef struct {
        logic [CNT_W-1:0]    count;
        logic [MEAN_W-1:0]   mean;
        logic [SAMPLE_W-1:0] selected;
        logic [SAMPLE_W-1:0] median;
        logic [SAMPLE_W-1:0] p95_value;
        logic [SAMPLE_W-1:0] p99_value;
    } stats_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample;
    logic                m_valid;
    logic                m_ready;
    logic [CNT_W-1:0]    m_count;
    logic [MEAN_W-1:0]   m_mean;
    logic [SAMPLE_W-1:0] m_selected;
    logic [SAMPLE_W-1:0] m_median;
    logic [SAMPLE_W-1:0] m_p95_value;
    logic [SAMPLE_W-1:0] m_p99_value;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    sliding_window_mean_percentile i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_count    (m_count),
        .m_mean     (m_mean),
        .m_selected (m_selected),
        .m_median   (m_median),
        .m_p95_value(m_p95_value),
        .m_p99_value(m_p99_value),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Window model state.
    logic [SAMPLE_W-1:0] ring_mem[DEPTH];
    logic [SAMPLE_W-1:0] sorted_mem[DEPTH];
    int unsigned         ring_head;
    int unsigned         held;
    logic [63:0]         window_sum;
    int unsigned         win_len;
    int unsigned         pct_sel;

    logic [SAMPLE_W-1:0] pending_samples[$];
    stats_t              expected_stats[$];
    int                  err_count;
    int                  cycle_count;
    int                  sent_total;
    int                  in_gap;
    int                  out_gap;
    bit                  quiet;
    logic                s_ready_q;
    logic                m_ready_q;

    function automatic void clear_window();
        ring_head  = 0;
        held       = 0;
        window_sum = '0;
    endfunction

    function automatic void apply_register(int idx, logic [31:0] value);
        int unsigned v;
        if (idx == REG_WINDOW_LENGTH) begin
            v = value & 32'h7F;
            if (v < 1) v = 1;
            if (v > DEPTH) v = DEPTH;
            win_len = v;
            clear_window();
        end else if (idx == REG_TARGET_PCT) begin
            v = value & 32'h3FFF;
            if (v > PCT_FULL) v = PCT_FULL;
            pct_sel = v;
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] rank_value(int unsigned pct, int unsigned n);
        longint unsigned r;
        r = (longint'(pct) * n + PCT_FULL - 1) / PCT_FULL;
        if (r < 1) r = 1;
        if (r > n) r = n;
        return sorted_mem[r - 1];
    endfunction

    function automatic stats_t window_update(logic [SAMPLE_W-1:0] smp);
        stats_t              res;
        int unsigned         p;
        int unsigned         i;
        logic [SAMPLE_W-1:0] old;
        if (held >= win_len) begin
            p   = ring_head % win_len;
            old = ring_mem[p];
            i   = 0;
            while (i < held && sorted_mem[i] != old) i++;
            if (i < held) begin
                for (; i + 1 < held; i++) sorted_mem[i] = sorted_mem[i + 1];
            end
            held        = win_len - 1;
            window_sum -= old;
            ring_mem[p] = smp;
            ring_head   = (p + 1) % win_len;
        end else begin
            ring_mem[(ring_head + held) % win_len] = smp;
        end
        i = held;
        while (i > 0 && sorted_mem[i - 1] > smp) begin
            sorted_mem[i] = sorted_mem[i - 1];
            i--;
        end
        sorted_mem[i] = smp;
        held++;
        window_sum += smp;
        res.count     = CNT_W'(held);
        res.mean      = MEAN_W'((window_sum << 8) / held);
        res.selected  = rank_value(pct_sel, held);
        res.median    = rank_value(5000, held);
        res.p95_value = rank_value(9500, held);
        res.p99_value = rank_value(9900, held);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one; none at all in quiet phases.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Input driver.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !(s_ready_q)) begin
            s_valid <= 1'b1;
        end else if (in_gap > 0) begin
            in_gap  <= in_gap - 1;
            s_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
            s_sample <= pending_samples[0];
            pending_samples.delete(0);
            s_valid  <= 1'b1;
            in_gap   <= pick_gap();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result-side backpressure: a new gap may follow each accepted result.
    always @(negedge aclk) begin
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (m_ready_q) out_gap <= pick_gap();
        end
    end

    // Monitor: predicts on each accepted sample, checks each accepted result.
    always @(posedge aclk) begin
        stats_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            s_ready_q <= s_valid && s_ready;
            m_ready_q <= m_valid && m_ready;
            if (aresetn && s_valid && s_ready) begin
                expected_stats.insert(expected_stats.size(), window_update(s_sample));
                sent_total <= sent_total + 1;
            end
            if (aresetn && m_valid && m_ready) begin
                if (expected_stats.size() == 0) begin
                    $error("result transaction with nothing expected");
                    err_count++;
                end else begin
                    want = expected_stats[0];
                    expected_stats.delete(0);
                    if (m_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, m_count);
                        err_count++;
                    end
                    if (m_mean !== want.mean) begin
                        $error("mean: expected %0h, got %0h", want.mean, m_mean);
                        err_count++;
                    end
                    if (m_selected !== want.selected) begin
                        $error("selected: expected %0h, got %0h", want.selected, m_selected);
                        err_count++;
                    end
                    if (m_median !== want.median) begin
                        $error("median: expected %0h, got %0h", want.median, m_median);
                        err_count++;
                    end
                    if (m_p95_value !== want.p95_value) begin
                        $error("p95_value: expected %0h, got %0h", want.p95_value, m_p95_value);
                        err_count++;
                    end
                    if (m_p99_value !== want.p99_value) begin
                        $error("p99_value: expected %0h, got %0h", want.p99_value, m_p99_value);
                        err_count++;
                    end
                end
            end
        end
    end

    task automatic reg_write(int idx, logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = 3'(idx * 4);
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        apply_register(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_samples.size() > 0 || s_valid || expected_stats.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Sample mix: full-range, small values with many duplicates, or extremes.
    function automatic logic [SAMPLE_W-1:0] pick_sample(int mode);
        case (mode)
            0: begin
                return $urandom();
            end
            1: begin
                return $urandom_range(0, 7);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    task automatic run_phase(int n, int mode);
        repeat (n) pending_samples.insert(pending_samples.size(), pick_sample(mode));
        wait_idle();
    endtask

    initial begin
        logic [SAMPLE_W-1:0] seq[$];
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_sample    = '0;
        m_ready     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_ready_q   = 1'b0;
        m_ready_q   = 1'b0;
        in_gap      = 0;
        out_gap     = 0;
        quiet       = 1'b0;
        err_count   = 0;
        cycle_count = 0;
        sent_total  = 0;
        win_len     = DEPTH;
        pct_sel     = 5000;
        clear_window();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, duplicates and alternating bit patterns at reset settings.
        seq = '{32'h0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1,
                32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h7, 32'h7, 32'h7,
                32'hFFFF_FFFE, 32'h1234_5678};
        foreach (seq[k]) pending_samples.insert(pending_samples.size(), seq[k]);
        wait_idle();

        // Window length zero, maximum percentile from an oversize write.
        reg_write(REG_WINDOW_LENGTH, 32'd0);
        reg_write(REG_TARGET_PCT, 32'h3FFF);
        run_phase(6, 2);
        // Window of one at percentile zero, then a window of two at percentile 10000.
        reg_write(REG_WINDOW_LENGTH, 32'd1);
        reg_write(REG_TARGET_PCT, 32'd0);
        run_phase(5, 2);
        reg_write(REG_WINDOW_LENGTH, 32'd2);
        reg_write(REG_TARGET_PCT, 32'd10000);
        run_phase(8, 1);
        // Oversize window write clamps to full capacity; fill past wrap.
        reg_write(REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
        reg_write(REG_TARGET_PCT, 32'd10001);
        quiet = 1'b1;
        run_phase(80, 1);
        quiet = 1'b0;
        reg_write(REG_TARGET_PCT, 32'd1);
        run_phase(80, 0);

        while (sent_total < TARGET_N) begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 2) == 0)
                    reg_write(REG_WINDOW_LENGTH, $urandom_range(60, 127));
                else
                    reg_write(REG_WINDOW_LENGTH, $urandom_range(1, 12));
            end
            case ($urandom_range(0, 3))
                0:       reg_write(REG_TARGET_PCT, $urandom());
                1:       reg_write(REG_TARGET_PCT, $urandom_range(0, 16383));
                default: reg_write(REG_TARGET_PCT, $urandom_range(0, 10000));
            endcase
            run_phase($urandom_range(30, 110), $urandom_range(0, 2));
        end

        wait_idle();
        if (err_count == 0 && expected_stats.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
